// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion lbl failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion lbl failed");

`endif

// ===== src/rcp_pkg.sv =====
`timescale 1ns / 1ps
package rcp_pkg;

  localparam int RX     = 4;
  localparam int TX     = 2;
  localparam int WIN    = 3;
  localparam int SNAP   = RX * TX;
  localparam int YCOL   = WIN * TX;
  localparam int NST    = RX * YCOL;
  localparam int CCOL   = 2 * YCOL;
  localparam int SROW   = RX * CCOL;
  localparam int FRAC   = 12;
  localparam int ACC_W  = 40;
  localparam int MUL_W  = 17;
  localparam int PROD_W = 2 * MUL_W;

  localparam int NST_W  = $clog2(NST);
  localparam int SNAP_W = $clog2(SNAP);
  localparam int OC_W   = $clog2(YCOL);
  localparam int KC_W   = $clog2(CCOL);
  localparam int KA_W   = $clog2(RX);
  localparam int IL_AW  = $clog2(RX * RX);
  localparam int IR_AW  = $clog2(YCOL * YCOL);
  localparam int RO_AW  = $clog2(SNAP * SROW);

  localparam logic [12:0] GAIN_RESET = 13'd3277;
  localparam logic [11:0] TANH_SAT   = 12'd4093;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_START  = 2'd2;

  localparam logic [2:0] WM_IN_LEFT   = 3'd0;
  localparam logic [2:0] WM_IN_RIGHT  = 3'd1;
  localparam logic [2:0] WM_RES_LEFT  = 3'd2;
  localparam logic [2:0] WM_RES_RIGHT = 3'd3;
  localparam logic [2:0] WM_READOUT   = 3'd4;

  typedef struct packed {
    logic [1:0]         op;
    logic [2:0]         weight_matrix;
    logic [8:0]         element_index;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pred_value;
    logic [2:0]         pred_index;
    logic               last_of_step;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SHIFT, S_RD, S_MUL, S_ACC, S_WB, S_TMUL, S_TWB, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    PH_SCALE, PH_LIN, PH_LRES, PH_RIGHT, PH_READ
  } phase_t;

  // Round half up from Q.24 to Q.12, saturate to 16 bits.
  function automatic logic signed [15:0] rnd_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] v;
    logic signed [ACC_W-1:0] q;
    v = acc + ACC_W'(2048);
    q = v >>> FRAC;
    if (q > ACC_W'(32767)) begin
      return 16'sh7FFF;
    end else if (q < -ACC_W'(32768)) begin
      return 16'sh8000;
    end
    return q[15:0];
  endfunction

  // tanh(k/8) in Q0.12.
  function automatic logic [11:0] tanh_tab(input logic [5:0] i);
    case (i)
      6'd0:  return 12'd0;
      6'd1:  return 12'd509;
      6'd2:  return 12'd1003;
      6'd3:  return 12'd1468;
      6'd4:  return 12'd1893;
      6'd5:  return 12'd2272;
      6'd6:  return 12'd2602;
      6'd7:  return 12'd2884;
      6'd8:  return 12'd3119;
      6'd9:  return 12'd3315;
      6'd10: return 12'd3475;
      6'd11: return 12'd3604;
      6'd12: return 12'd3707;
      6'd13: return 12'd3790;
      6'd14: return 12'd3856;
      6'd15: return 12'd3908;
      6'd16: return 12'd3949;
      6'd17: return 12'd3981;
      6'd18: return 12'd4006;
      6'd19: return 12'd4026;
      6'd20: return 12'd4041;
      6'd21: return 12'd4053;
      6'd22: return 12'd4063;
      6'd23: return 12'd4070;
      6'd24: return 12'd4076;
      6'd25: return 12'd4080;
      6'd26: return 12'd4084;
      6'd27: return 12'd4086;
      6'd28: return 12'd4089;
      6'd29: return 12'd4090;
      6'd30: return 12'd4091;
      6'd31: return 12'd4092;
      default: return TANH_SAT;
    endcase
  endfunction

endpackage

// ===== src/reservoir_channel_predictor_core.sv =====
`timescale 1ns / 1ps
// Echo state network channel predictor. Weight writes, start and non-final sample
// transactions complete as they are accepted. The last sample of a snapshot starts a
// step run by a single 17x17 multiply-accumulate unit under a sequencer: a shift
// step, then a read, multiply and accumulate step per product, a write-back per
// result and a tanh interpolation multiply and write-back per reservoir entry, over
// 24 scale, 2x96 left, 288 right and 384 readout products, waiting on output stalls.
// The eight predictions leave one at a time; no new transaction or gain write is
// taken until the last one is accepted.
module reservoir_channel_predictor_core
  import rcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data
);

`include "assert_macros.svh"

  state_t state, state_next;
  phase_t phase;

  logic [12:0] gain;
  logic signed [15:0] win [NST];
  logic signed [15:0] st [NST];
  logic signed [15:0] xs [NST];
  logic signed [15:0] t1 [NST];
  logic signed [15:0] t2 [NST];
  logic signed [15:0] pend [SNAP];

  logic signed [15:0] il_mem [RX*RX];
  logic signed [15:0] rl_mem [RX*RX];
  logic signed [15:0] ir_mem [YCOL*YCOL];
  logic signed [15:0] rr_mem [YCOL*YCOL];
  logic signed [15:0] ro_mem [SNAP*SROW];
  logic signed [15:0] il_rd, rl_rd, ir_rd, rr_rd, ro_rd;

  logic [SNAP_W-1:0] oa;
  logic [OC_W-1:0]   oc;
  logic [KC_W-1:0]   kc;
  logic [KA_W-1:0]   ka;
  logic [RO_AW-1:0]  ro_addr;

  logic signed [MUL_W-1:0]  opa_q;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic [8:0]  tf;
  logic [11:0] ty0;
  logic        tneg, tsat;
  out_item_t   out_q;

  logic in_fire;
  logic [KC_W-1:0]  krow;
  logic [KC_W:0]    klim;
  logic             inner_last, outer_last;
  logic [NST_W-1:0] i_lin;
  logic [IL_AW-1:0] il_ra;
  logic [IR_AW-1:0] ir_ra;
  logic signed [15:0]      opa_sel;
  logic signed [MUL_W-1:0] opb_sel, mul_b;

  // tanh prep
  logic signed [15:0] tx;
  logic [16:0] tax;
  logic [4:0]  tidx;
  logic [11:0] t_lo, t_hi;
  logic [12:0] ty;
  logic [11:0] tys;

  assign in_fire = in_valid && in_ready;

  always_comb begin
    krow  = (kc < KC_W'(YCOL)) ? kc : kc - KC_W'(YCOL);
    i_lin = NST_W'(oa * YCOL + oc);
    il_ra = IL_AW'(oa * RX + kc);
    ir_ra = IR_AW'(krow * YCOL + oc);
    case (phase)
      PH_SCALE: klim = (KC_W+1)'(1);
      PH_LIN:   klim = (KC_W+1)'(RX);
      PH_LRES:  klim = (KC_W+1)'(RX);
      PH_RIGHT: klim = (KC_W+1)'(2 * YCOL);
      PH_READ:  klim = (KC_W+1)'(CCOL);
      default:  klim = (KC_W+1)'(1);
    endcase
    inner_last = ({1'b0, kc} == klim - 1'b1) && (phase != PH_READ || ka == KA_W'(RX - 1));
    outer_last = (phase == PH_READ) ? (oa == SNAP_W'(SNAP - 1))
                                    : (oa == SNAP_W'(RX - 1) && oc == OC_W'(YCOL - 1));
  end

  always_comb begin
    case (phase)
      PH_SCALE: opa_sel = win[i_lin];
      PH_LIN:   opa_sel = xs[NST_W'(kc * YCOL + oc)];
      PH_LRES:  opa_sel = st[NST_W'(kc * YCOL + oc)];
      PH_RIGHT: opa_sel = (kc < KC_W'(YCOL)) ? t1[NST_W'(oa * YCOL + krow)]
                                             : t2[NST_W'(oa * YCOL + krow)];
      PH_READ:  opa_sel = (kc < KC_W'(YCOL)) ? st[NST_W'(ka * YCOL + krow)]
                                             : win[NST_W'(ka * YCOL + krow)];
      default:  opa_sel = '0;
    endcase
    case (phase)
      PH_SCALE: opb_sel = $signed({4'b0, gain});
      PH_LIN:   opb_sel = MUL_W'(il_rd);
      PH_LRES:  opb_sel = MUL_W'(rl_rd);
      PH_RIGHT: opb_sel = (kc < KC_W'(YCOL)) ? MUL_W'(ir_rd) : MUL_W'(rr_rd);
      PH_READ:  opb_sel = MUL_W'(ro_rd);
      default:  opb_sel = '0;
    endcase
    mul_b = (state == S_TMUL) ? $signed({8'b0, tf}) : opb_sel;
  end

  always_comb begin
    tx   = rnd_sat(acc);
    tax  = tx[15] ? 17'(-{tx[15], tx}) : {1'b0, tx};
    tidx = tax[13:9];
    t_lo = tanh_tab({1'b0, tidx});
    t_hi = tanh_tab(6'({1'b0, tidx} + 6'd1));
    ty   = 13'(ty0) + 13'((prod + PROD_W'(256)) >>> 9);
    tys  = tsat ? TANH_SAT : ty[11:0];
  end

  // weight memories
  always_ff @(posedge clk) begin
    if (in_fire && in_data.op == OP_WRITE) begin
      if (in_data.weight_matrix == WM_IN_LEFT && in_data.element_index < 9'(RX * RX)) begin
        il_mem[IL_AW'(in_data.element_index)] <= in_data.value;
      end
      if (in_data.weight_matrix == WM_RES_LEFT && in_data.element_index < 9'(RX * RX)) begin
        rl_mem[IL_AW'(in_data.element_index)] <= in_data.value;
      end
      if (in_data.weight_matrix == WM_IN_RIGHT &&
          in_data.element_index < 9'(YCOL * YCOL)) begin
        ir_mem[IR_AW'(in_data.element_index)] <= in_data.value;
      end
      if (in_data.weight_matrix == WM_RES_RIGHT &&
          in_data.element_index < 9'(YCOL * YCOL)) begin
        rr_mem[IR_AW'(in_data.element_index)] <= in_data.value;
      end
      if (in_data.weight_matrix == WM_READOUT &&
          in_data.element_index < 9'(SNAP * SROW)) begin
        ro_mem[RO_AW'(in_data.element_index)] <= in_data.value;
      end
    end
    il_rd <= il_mem[il_ra];
    rl_rd <= rl_mem[il_ra];
    ir_rd <= ir_mem[ir_ra];
    rr_rd <= rr_mem[ir_ra];
    ro_rd <= ro_mem[ro_addr];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire && in_data.op == OP_SAMPLE &&
            in_data.element_index == 9'(SNAP - 1)) begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: state_next = S_RD;
      S_RD:    state_next = S_MUL;
      S_MUL:   state_next = S_ACC;
      S_ACC:   state_next = inner_last ? S_WB : S_RD;
      S_WB: begin
        if (phase == PH_RIGHT) begin
          state_next = S_TMUL;
        end else if (phase == PH_READ) begin
          state_next = S_OUT;
        end else begin
          state_next = S_RD;
        end
      end
      S_TMUL:  state_next = S_TWB;
      S_TWB:   state_next = S_RD;
      S_OUT: begin
        if (out_ready) begin
          state_next = outer_last ? S_IDLE : S_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == S_IDLE);
    cfg_ready = (state == S_IDLE);
    out_valid = (state == S_OUT);
    out_data  = out_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_SCALE;
      gain  <= GAIN_RESET;
      oa    <= '0;
      oc    <= '0;
      kc    <= '0;
      ka    <= '0;
      for (int i = 0; i < NST; i++) begin
        win[i] <= '0;
        st[i]  <= '0;
      end
      for (int i = 0; i < SNAP; i++) begin
        pend[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        gain <= cfg_data;
      end

      if (state == S_IDLE && in_fire) begin
        if (in_data.op == OP_START) begin
          for (int i = 0; i < NST; i++) begin
            win[i] <= '0;
            st[i]  <= '0;
          end
          for (int i = 0; i < SNAP; i++) begin
            pend[i] <= '0;
          end
        end else if (in_data.op == OP_SAMPLE && in_data.element_index < 9'(SNAP)) begin
          pend[SNAP_W'(in_data.element_index)] <= in_data.value;
        end
      end

      // advance to the next result, or to the next phase
      if (state == S_WB && phase != PH_RIGHT && phase != PH_READ ||
          state == S_TWB || state == S_OUT && out_ready) begin
        if (outer_last) begin
          oa <= '0;
          oc <= '0;
          case (phase)
            PH_SCALE: phase <= PH_LIN;
            PH_LIN:   phase <= PH_LRES;
            PH_LRES:  phase <= PH_RIGHT;
            PH_RIGHT: phase <= PH_READ;
            default:  phase <= PH_SCALE;
          endcase
        end else if (phase == PH_READ || oc == OC_W'(YCOL - 1)) begin
          oa <= oa + 1'b1;
          oc <= '0;
        end else begin
          oc <= oc + 1'b1;
        end
      end

      case (state)
        S_SHIFT: begin
          for (int a = 0; a < RX; a++) begin
            for (int j = WIN - 1; j > 0; j--) begin
              for (int k = 0; k < TX; k++) begin
                win[a*YCOL + j*TX + k] <= win[a*YCOL + (j-1)*TX + k];
              end
            end
            for (int k = 0; k < TX; k++) begin
              win[a*YCOL + k] <= pend[a*TX + k];
            end
          end
          phase   <= PH_SCALE;
          oa      <= '0;
          oc      <= '0;
          kc      <= '0;
          ka      <= '0;
          ro_addr <= '0;
          acc     <= '0;
        end
        S_RD: opa_q <= MUL_W'(opa_sel);
        S_MUL, S_TMUL: prod <= opa_q * mul_b;
        S_ACC: begin
          acc <= acc + ACC_W'(prod);
          if (phase == PH_READ) begin
            ro_addr <= ro_addr + 1'b1;
          end
          if ({1'b0, kc} == klim - 1'b1) begin
            kc <= '0;
            ka <= ka + 1'b1;
          end else begin
            kc <= kc + 1'b1;
          end
        end
        S_WB: begin
          acc <= '0;
          ka  <= '0;
          case (phase)
            PH_SCALE: xs[i_lin] <= rnd_sat(acc);
            PH_LIN:   t1[i_lin] <= rnd_sat(acc);
            PH_LRES:  t2[i_lin] <= rnd_sat(acc);
            PH_RIGHT: begin
              tneg  <= tx[15];
              tsat  <= (tax[16:14] != 3'd0);
              ty0   <= t_lo;
              tf    <= tax[8:0];
              opa_q <= MUL_W'(t_hi - t_lo);
            end
            PH_READ: begin
              out_q.pred_value   <= rnd_sat(acc);
              out_q.pred_index   <= oa;
              out_q.last_of_step <= (oa == SNAP_W'(SNAP - 1));
            end
            default: ;
          endcase
        end
        S_TWB: st[i_lin] <= tneg ? -$signed({4'b0, tys}) : $signed({4'b0, tys});
        default: ;
      endcase
    end
  end

  `ASSERT_IMP(a_out_only_in_out, clk, rst, out_valid, state == S_OUT)
  `ASSERT_IMP(a_no_in_while_out, clk, rst, in_ready, !out_valid)
  `ASSERT_IMP(a_last_index, clk, rst, out_valid && out_data.last_of_step, out_data.pred_index == 3'(SNAP - 1))
  `ASSERT_NEXT(a_mul_then_acc, clk, rst, state == S_MUL, state == S_ACC)

endmodule
